// ===== src/sspd_pkg.sv =====
// ----------------------------------------------------------------------------
// sspd_pkg: shared types and constants for the servo slew / PWM duty block
// Word layouts, command codes and the fixed timing constants of the servo.
// ----------------------------------------------------------------------------
package sspd_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned DUTY_W  = 14;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned STEP_W  = 11;

  localparam int unsigned DUTY_BITS_DEF = 14;
  localparam int unsigned MAX_ANGLE_DEF = 180;

  localparam longint unsigned PULSE_MIN_US  = 500;
  localparam longint unsigned PULSE_SPAN_US = 2000;
  localparam longint unsigned PERIOD_US     = 20000;
  localparam int unsigned     UPDATE_MS     = 20;
  localparam int unsigned     MS_PER_S      = 1000;

  // step = floor(speed * UPDATE_MS / MS_PER_S) = floor(speed / STEP_DIV),
  // done as a multiply by a rounded-up reciprocal; exact for 16-bit speeds.
  localparam int unsigned STEP_DIV   = MS_PER_S / UPDATE_MS;
  localparam int unsigned STEP_SHIFT = 22;
  localparam int unsigned STEP_RECIP = ((1 << STEP_SHIFT) + STEP_DIV - 1) / STEP_DIV;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned PROD_W     = SPD_W + RECIP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_TICK = 2'd2
  } sspd_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] angle_request;
    logic [SPD_W-1:0] speed_dps;
  } sspd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_count;
    logic [ANGLE_W-1:0] current_angle;
    logic               at_target;
  } sspd_out_t;

  // position after an item, handed from the slew unit to the output stage
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               at_target;
  } sspd_pos_t;

endpackage

// ===== src/sspd_slew.sv =====
// ----------------------------------------------------------------------------
// sspd_slew: angle / target / step state and the per-word update
// Applies set, move and tick commands and presents the resulting position.
// ----------------------------------------------------------------------------
module sspd_slew #(
  parameter int unsigned MaxAngle = sspd_pkg::MAX_ANGLE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sspd_pkg::sspd_in_t item_i,
  output sspd_pkg::sspd_pos_t pos_o
);
  import sspd_pkg::*;

  localparam logic [ANGLE_W-1:0] MaxA = ANGLE_W'(MaxAngle);

  logic [ANGLE_W-1:0] angle_q, angle_d;
  logic [ANGLE_W-1:0] goal_q, goal_d;
  logic [STEP_W-1:0]  step_q, step_d;

  logic [ANGLE_W-1:0] req_clamp;
  logic [PROD_W-1:0]  step_prod;
  logic [STEP_W-1:0]  step_new;
  logic [STEP_W:0]    up_sum;
  logic [ANGLE_W-1:0] down_gap;

  assign req_clamp = (item_i.angle_request > REQ_W'(MaxA)) ? MaxA
                                                           : item_i.angle_request[ANGLE_W-1:0];

  // zero speed gives a zero quotient, which the floor of one covers anyway
  assign step_prod = PROD_W'(item_i.speed_dps) * PROD_W'(STEP_RECIP);
  assign step_new  = (step_prod[PROD_W-1:STEP_SHIFT] == '0) ? STEP_W'(1)
                                                            : step_prod[STEP_SHIFT+STEP_W-1:STEP_SHIFT];

  assign up_sum   = (STEP_W+1)'(angle_q) + (STEP_W+1)'(step_q);
  assign down_gap = angle_q - goal_q;

  always_comb begin
    angle_d = angle_q;
    goal_d  = goal_q;
    step_d  = step_q;
    if (en_i) begin
      case (item_i.cmd)
        CMD_SET: begin
          angle_d = req_clamp;
          goal_d  = req_clamp;
        end
        CMD_MOVE: begin
          goal_d = req_clamp;
          step_d = step_new;
        end
        CMD_TICK: begin
          if (angle_q < goal_q) begin
            angle_d = (up_sum > (STEP_W+1)'(goal_q)) ? goal_q : up_sum[ANGLE_W-1:0];
          end else if (angle_q > goal_q) begin
            angle_d = (step_q >= STEP_W'(down_gap)) ? goal_q
                                                    : angle_q - step_q[ANGLE_W-1:0];
          end
        end
        default: begin
          // unused code: state holds
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      goal_q  <= '0;
      step_q  <= STEP_W'(1);
    end else begin
      angle_q <= angle_d;
      goal_q  <= goal_d;
      step_q  <= step_d;
    end
  end

  assign pos_o.angle     = angle_d;
  assign pos_o.at_target = (angle_d == goal_d);

  step_nonzero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0) else $error("step size reached zero");

  angle_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q <= MaxA && goal_q <= MaxA) else $error("angle state out of range");

  tick_no_pass_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.cmd == CMD_TICK && angle_q <= goal_q) |=>
      (angle_q <= $past(goal_q) && angle_q >= $past(angle_q)))
    else $error("tick overshot target");

endmodule

// ===== src/sspd_duty.sv =====
// ----------------------------------------------------------------------------
// sspd_duty: angle to PWM compare count
// Constant table over all angle codes, built at elaboration.
// ----------------------------------------------------------------------------
module sspd_duty #(
  parameter int unsigned DutyBits = sspd_pkg::DUTY_BITS_DEF,
  parameter int unsigned MaxAngle = sspd_pkg::MAX_ANGLE_DEF
) (
  input  logic [sspd_pkg::ANGLE_W-1:0] angle_i,
  output logic [sspd_pkg::DUTY_W-1:0]  duty_o
);
  import sspd_pkg::*;

  localparam int unsigned      Entries = 1 << ANGLE_W;
  localparam longint unsigned  Full    = (64'd1 << DutyBits) - 64'd1;

  logic [DUTY_W-1:0] lut [Entries];

  for (genvar i = 0; i < Entries; i++) begin : g_lut
    localparam longint unsigned Pulse = PULSE_MIN_US + (longint'(i) * PULSE_SPAN_US) / MaxAngle;
    localparam longint unsigned Duty  = (Pulse * Full) / PERIOD_US;
    localparam logic [63:0]     DutyV = Duty;
    assign lut[i] = DutyV[DUTY_W-1:0];
  end

  assign duty_o = lut[angle_i];

endmodule

// ===== src/servo_slew_pwm_duty.sv =====
// ----------------------------------------------------------------------------
// servo_slew_pwm_duty: servo setpoint ramp with PWM duty output
// Input register, slew update and duty lookup, result register.
// ----------------------------------------------------------------------------
// One word in, one word out. A word is taken into the input register, and when
// it advances it updates the angle state and its result (duty count,
// current angle, at-target flag) is loaded into the output register. A new
// word can be taken every cycle while the output is not stalled. The output
// register holds its word while out_stall_i is high; input words keep flowing
// until the input register also holds a word that cannot move on.
module servo_slew_pwm_duty #(
  parameter int unsigned DutyBits = sspd_pkg::DUTY_BITS_DEF,
  parameter int unsigned MaxAngle = sspd_pkg::MAX_ANGLE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sspd_pkg::sspd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sspd_pkg::sspd_out_t out_data_o
);
  import sspd_pkg::*;

  logic      in_valid_q;
  sspd_in_t  in_data_q;
  logic      out_valid_q;
  sspd_out_t out_data_q, out_data_d;
  logic      adv;
  logic      in_take;
  sspd_pos_t pos;
  logic [DUTY_W-1:0] duty;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  sspd_slew #(
    .MaxAngle(MaxAngle)
  ) u_slew (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .item_i(in_data_q),
    .pos_o (pos)
  );

  sspd_duty #(
    .DutyBits(DutyBits),
    .MaxAngle(MaxAngle)
  ) u_duty (
    .angle_i(pos.angle),
    .duty_o (duty)
  );

  assign out_data_d.duty_count    = duty;
  assign out_data_d.current_angle = pos.angle;
  assign out_data_d.at_target     = pos.at_target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  adv_fills_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q) else $error("advanced word did not reach output");

  stall_needs_word_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked word");

  out_angle_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.current_angle <= ANGLE_W'(MaxAngle)))
    else $error("output angle out of range");

endmodule

// ===== verif/sspd_checker.sv =====
// ----------------------------------------------------------------------------
// sspd_checker: result predictor and scoreboard for servo_slew_pwm_duty
// Watches both channels. Each accepted input word advances a private copy of
// the servo state, and the expected result word is queued. Each accepted
// output word is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspd_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sspd_pkg::sspd_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sspd_pkg::sspd_out_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import sspd_pkg::*;

  localparam int unsigned MaxReports = 10;

  logic [ANGLE_W-1:0] servo_angle_q;
  logic [ANGLE_W-1:0] servo_goal_q;
  logic [STEP_W-1:0]  servo_step_q;
  sspd_out_t          servo_result_q[$];

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [REQ_W-1:0] req);
    return (req > MAX_ANGLE_DEF) ? ANGLE_W'(MAX_ANGLE_DEF) : req[ANGLE_W-1:0];
  endfunction

  function automatic sspd_out_t servo_result(input logic [ANGLE_W-1:0] angle,
                                             input logic [ANGLE_W-1:0] goal);
    longint unsigned full;
    longint unsigned pulse;
    longint unsigned duty;
    sspd_out_t       r;
    full  = (longint'(1) << DUTY_BITS_DEF) - 1;
    pulse = PULSE_MIN_US + (longint'(angle) * PULSE_SPAN_US) / MAX_ANGLE_DEF;
    duty  = (pulse * full) / PERIOD_US;
    r.duty_count    = duty[DUTY_W-1:0];
    r.current_angle = angle;
    r.at_target     = (angle == goal);
    return r;
  endfunction

  // updates the servo state for one word and returns its result word
  task automatic advance_servo(input sspd_in_t w, output sspd_out_t r);
    int unsigned now;
    int unsigned goal;
    int unsigned stp;
    int unsigned spd;
    now  = servo_angle_q;
    goal = servo_goal_q;
    stp  = servo_step_q;
    case (w.cmd)
      CMD_SET: begin
        now  = clamp_angle(w.angle_request);
        goal = now;
      end
      CMD_MOVE: begin
        spd = (w.speed_dps == 0) ? 1 : w.speed_dps;
        stp = (spd * UPDATE_MS) / MS_PER_S;
        if (stp < 1) stp = 1;
        servo_step_q = stp[STEP_W-1:0];
        goal = clamp_angle(w.angle_request);
      end
      CMD_TICK: begin
        // never step past the goal in either direction
        if (now < goal) begin
          now = (now + stp > goal) ? goal : now + stp;
        end else if (now > goal) begin
          now = (stp >= now - goal) ? goal : now - stp;
        end
      end
      default: ;
    endcase
    servo_angle_q = now[ANGLE_W-1:0];
    servo_goal_q  = goal[ANGLE_W-1:0];
    r = servo_result(servo_angle_q, servo_goal_q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sspd_out_t want;
    sspd_out_t got;
    if (!rst_ni) begin
      servo_angle_q = '0;
      servo_goal_q  = '0;
      servo_step_q  = STEP_W'(1);
      servo_result_q.delete();
      pending_o     = 0;
      fail_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (servo_result_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= MaxReports)
            $display("%0t: unexpected result word duty=%0d angle=%0d at_target=%0b",
                     $realtime, got.duty_count, got.current_angle, got.at_target);
        end else begin
          want = servo_result_q.pop_front();
          if (got !== want) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= MaxReports) begin
              $write("%0t: result mismatch: exp duty=%0d angle=%0d at_target=%0b",
                     $realtime, want.duty_count, want.current_angle, want.at_target);
              $display(", got duty=%0d angle=%0d at_target=%0b",
                       got.duty_count, got.current_angle, got.at_target);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_servo(in_data_i, want);
        servo_result_q.push_back(want);
      end
      pending_o = servo_result_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for servo_slew_pwm_duty
// Drives directed and random set / move / tick and unused-code words through the
// block under several idle and stall mixes, with one long output hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sspd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ItemsPerPhase = 260;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  sspd_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sspd_out_t   out_data;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          hold_req  = 1'b0;
  int unsigned quiet_cycles = 0;

  always #2 clk = ~clk;

  servo_slew_pwm_duty dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  sspd_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic sspd_in_t servo_word(input logic [CMD_W-1:0] cmd,
                                          input logic [REQ_W-1:0] req,
                                          input logic [SPD_W-1:0] spd);
    sspd_in_t w;
    w.cmd           = cmd;
    w.angle_request = req;
    w.speed_dps     = spd;
    return w;
  endfunction

  // mostly ticks after moves, so ramps run to their goals
  function automatic sspd_in_t random_word();
    int unsigned      k;
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] req;
    logic [SPD_W-1:0] spd;
    k = $urandom_range(0, 99);
    if (k < 8)       cmd = CMD_SET;
    else if (k < 25) cmd = CMD_MOVE;
    else if (k < 93) cmd = CMD_TICK;
    else             cmd = CMD_UNUSED;
    req = ($urandom_range(0, 3) == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 200));
    k = $urandom_range(0, 99);
    if (k < 10)      spd = '0;
    else if (k < 35) spd = SPD_W'($urandom);
    else             spd = SPD_W'($urandom_range(0, 600));
    return servo_word(cmd, req, spd);
  endfunction

  // each cycle is idle with probability idle_pct before the word goes out
  task automatic send_word(input sspd_in_t w);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, clamps, extreme speeds, upward overshoot, downward ramp
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_UNUSED, 16'hFFFF,  16'hFFFF));
    send_word(servo_word(CMD_SET,    16'd180,   16'd0));
    send_word(servo_word(CMD_SET,    16'd181,   16'hFFFF));
    send_word(servo_word(CMD_SET,    16'hFFFF,  16'd7));
    send_word(servo_word(CMD_SET,    16'd0,     16'd0));
    send_word(servo_word(CMD_MOVE,   16'd3,     16'd0));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_TICK,   16'hFFFF,  16'hFFFF));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_MOVE,   16'hFFFF,  16'hFFFF));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_MOVE,   16'd100,   16'd49));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_MOVE,   16'd0,     16'd2549));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_SET,    16'd90,    16'd0));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));
    send_word(servo_word(CMD_MOVE,   16'd0,     16'd50));
    send_word(servo_word(CMD_UNUSED, 16'd0,     16'd0));
    send_word(servo_word(CMD_TICK,   16'd0,     16'd0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // hold the output while words keep coming, to back up the input
        if (phase == 0 && i == 40) hold_req = 1'b1;
        send_word(random_word());
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sspd_pkg.sv
src/sspd_slew.sv
src/sspd_duty.sv
src/servo_slew_pwm_duty.sv
verif/sspd_checker.sv
verif/tb_top.sv
